/* src/cfsm_pkg.sv */
// shared types and codes for the circular fifo with search and min/max
package cfsm_pkg;

   typedef enum logic [2:0] {
      OP_ENQUEUE = 3'd0,
      OP_DEQUEUE = 3'd1,
      OP_MINMAX  = 3'd2,
      OP_SEARCH  = 3'd3,
      OP_DUMP    = 3'd4
   } opcode_type;

   typedef enum logic [3:0] {
      ST_ENQUEUED = 4'd0,
      ST_FULL     = 4'd1,
      ST_DEQUEUED = 4'd2,
      ST_EMPTY    = 4'd3,
      ST_MINMAX   = 4'd4,
      ST_MATCH    = 4'd5,
      ST_NOTFOUND = 4'd6,
      ST_ELEMENT  = 4'd7,
      ST_RESERVED = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_DEQ_WAIT,
      S_WALK,
      S_FINAL
   } state_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] item_in;
   } req_type;

   typedef struct packed {
      logic [3:0] status;
      logic [7:0] item_out;
      logic [7:0] max_out;
      logic [3:0] position;
      logic [3:0] occupancy;
      logic       last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       issue;
      logic       eval;
      logic       pend_set;
      logic       emit;
      status_type emit_sel;
      logic       emit_last;
      logic       do_enq;
      logic       do_deq;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] op;
      logic       empty;
      logic       full;
      logic       issue_done;
      logic       rd_vld;
      logic       match;
      logic       eval_last;
      logic       pend_vld;
      logic       out_free;
   } dp_status_type;

endpackage

/* src/circular_fifo_search_minmax.sv */
// top level of the circular byte fifo with search, min/max and dump
//
// requests come in on req_valid/req_stall/req_data (command and byte); results
// leave on rsp_valid/rsp_stall/rsp_data. a request is taken when valid is high
// and stall is low. one request is worked at a time: req_stall stays high from
// acceptance until the last result of that request sits in the result register.
// enqueue, dequeue, reserved commands and empty cases give one result; a dequeue
// first reads the head entry from the store. min/max, search and dump walk the
// held entries through the store's registered read port, one entry per cycle
// whenever each new result can be placed, and stop after the last held entry.
// search and dump may give several results, the last one flagged by last.
// a stalled result holds in the result register; the walk pauses while a new
// result cannot be placed, so nothing is lost. the next request is accepted
// while the final result still waits to be taken.
// reset empties the fifo (head, tail and count to zero) and drops any pending
// result; store contents are not cleared and are read only after being written.
module circular_fifo_search_minmax
   import cfsm_pkg::*;
#(
   parameter int DEPTH = 8
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_stat;

   cfsm_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (dp_stat),
      .cmd       (ctl_cmd)
   );

   cfsm_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (ctl_cmd),
      .stat      (dp_stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // a result is only placed when the result register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.emit |-> dp_stat.out_free)
      else $error("result placed over a waiting result");

   // no store write when full
   a_enq_room: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.do_enq |-> !dp_stat.full)
      else $error("enqueue into full store");

   // the walk never reads beyond the held entries
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.issue |-> !dp_stat.issue_done)
      else $error("store read beyond fill count");

   // an accepted request blocks the next one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in work");
`endif

endmodule

/* src/cfsm_ctl.sv */
// command sequencer for the circular fifo
module cfsm_ctl
   import cfsm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type stat,
   output ctl_cmd_type   cmd
);

   state_type state_ff;
   state_type state_in;
   logic      stall_eval;
   logic      eval_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.emit_sel  = ST_ENQUEUED;
      req_stall     = (state_ff != S_IDLE);
      stall_eval    = 1'b0;
      eval_go       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.op)
               OP_ENQUEUE: begin
                  if (stat.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_last = 1'b1;
                     cmd.emit_sel  = stat.full ? ST_FULL : ST_ENQUEUED;
                     cmd.do_enq    = !stat.full;
                     state_in      = S_IDLE;
                  end
               end
               OP_DEQUEUE: begin
                  if (!stat.empty) begin
                     cmd.issue = 1'b1;
                     state_in  = S_DEQ_WAIT;
                  end else if (stat.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_last = 1'b1;
                     cmd.emit_sel  = ST_EMPTY;
                     state_in      = S_IDLE;
                  end
               end
               OP_MINMAX, OP_SEARCH, OP_DUMP: begin
                  if (!stat.empty) begin
                     state_in = S_WALK;
                  end else if (stat.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_last = 1'b1;
                     cmd.emit_sel  = (stat.op == OP_SEARCH) ? ST_NOTFOUND : ST_EMPTY;
                     state_in      = S_IDLE;
                  end
               end
               default: begin
                  if (stat.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_last = 1'b1;
                     cmd.emit_sel  = ST_RESERVED;
                     state_in      = S_IDLE;
                  end
               end
            endcase
         end
         S_DEQ_WAIT: begin
            if (stat.rd_vld && stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               cmd.emit_sel  = ST_DEQUEUED;
               cmd.do_deq    = 1'b1;
               cmd.eval      = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_WALK: begin
            // hold the read pipe while a result cannot be placed
            stall_eval = stat.rd_vld && !stat.out_free &&
                         ((stat.op == OP_DUMP) ||
                          ((stat.op == OP_SEARCH) && stat.match && stat.pend_vld));
            eval_go    = stat.rd_vld && !stall_eval;
            cmd.issue  = !stat.issue_done && !stall_eval;
            cmd.eval   = eval_go;
            if (eval_go && (stat.op == OP_DUMP)) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = ST_ELEMENT;
               cmd.emit_last = stat.eval_last;
            end
            if (eval_go && (stat.op == OP_SEARCH) && stat.match) begin
               cmd.pend_set = 1'b1;
               if (stat.pend_vld) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = ST_MATCH;
               end
            end
            if (eval_go && stat.eval_last) begin
               state_in = (stat.op == OP_DUMP) ? S_IDLE : S_FINAL;
            end
         end
         S_FINAL: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               if (stat.op == OP_MINMAX) begin
                  cmd.emit_sel = ST_MINMAX;
               end else begin
                  cmd.emit_sel = stat.pend_vld ? ST_MATCH : ST_NOTFOUND;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* src/cfsm_dp.sv */
// store, pointers, walk registers and result register of the circular fifo
module cfsm_dp
   import cfsm_pkg::*;
#(
   parameter int DEPTH = 8
)(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  ctl_cmd_type   cmd,
   output dp_status_type stat,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EXT_W = (CNT_W > 4) ? CNT_W : 4;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   logic [7:0]       mem [DEPTH];
   logic [PTR_W-1:0] head_ff, tail_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] iss_ff, pos_ff, pend_pos_ff;
   logic [CNT_W-1:0] pos_next;
   logic [2:0]       op_ff;
   logic [7:0]       item_ff;
   logic [7:0]       rd_data_ff;
   logic             rd_vld_ff;
   logic [7:0]       min_ff, max_ff;
   logic             pend_vld_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;
   logic [EXT_W-1:0] occ_ext, pos_ext, pend_ext;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   assign pos_next = pos_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (cmd.do_enq) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.do_deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign occ_ext  = EXT_W'(count_in);
   assign pos_ext  = EXT_W'(pos_next);
   assign pend_ext = EXT_W'(pend_pos_ff);

   always_ff @(posedge clock) begin
      if (cmd.do_enq) begin
         mem[tail_ff] <= item_ff;
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         iss_ff       <= '0;
         pos_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.do_enq) begin
            tail_ff <= ptr_inc(tail_ff);
         end
         if (cmd.do_deq) begin
            head_ff <= ptr_inc(head_ff);
         end
         if (cmd.load) begin
            rd_ptr_ff   <= head_ff;
            iss_ff      <= '0;
            pos_ff      <= '0;
            pend_vld_ff <= 1'b0;
         end else begin
            if (cmd.issue) begin
               rd_ptr_ff <= ptr_inc(rd_ptr_ff);
               iss_ff    <= iss_ff + 1'b1;
            end
            if (cmd.eval) begin
               pos_ff <= pos_next;
            end
            if (cmd.pend_set) begin
               pend_vld_ff <= 1'b1;
            end
         end
         if (cmd.issue) begin
            rd_vld_ff <= 1'b1;
         end else if (cmd.eval) begin
            rd_vld_ff <= 1'b0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_data.cmd;
         item_ff <= req_data.item_in;
         min_ff  <= 8'hFF;
         max_ff  <= 8'h00;
      end else if (cmd.eval) begin
         if (rd_data_ff < min_ff) begin
            min_ff <= rd_data_ff;
         end
         if (rd_data_ff > max_ff) begin
            max_ff <= rd_data_ff;
         end
      end
      if (cmd.pend_set) begin
         pend_pos_ff <= pos_next;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in           = '0;
      rsp_in.status    = cmd.emit_sel;
      rsp_in.last      = cmd.emit_last;
      rsp_in.occupancy = occ_ext[3:0];
      case (cmd.emit_sel)
         ST_DEQUEUED: begin
            rsp_in.item_out = rd_data_ff;
         end
         ST_MINMAX: begin
            rsp_in.item_out = min_ff;
            rsp_in.max_out  = max_ff;
         end
         ST_MATCH: begin
            rsp_in.position = pend_ext[3:0];
         end
         ST_ELEMENT: begin
            rsp_in.item_out = rd_data_ff;
            rsp_in.position = pos_ext[3:0];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      stat            = '0;
      stat.op         = op_ff;
      stat.empty      = (count_ff == '0);
      stat.full       = (count_ff == CNT_W'(DEPTH));
      stat.issue_done = (iss_ff == count_ff);
      stat.rd_vld     = rd_vld_ff;
      stat.match      = (rd_data_ff == item_ff);
      stat.eval_last  = (pos_next == count_ff);
      stat.pend_vld   = pend_vld_ff;
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
